// File: hw/rtl/mmh_pkg.sv
// ----------------------------------------------------------------------------
// MurmurHash64A engine package
// Shared constants, operation codes and the command and status structures
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mmh_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hC6A4_A793_5BD1_E995;
  localparam int unsigned MIX_SHIFT = 47;

  // Multiply operations. Each one names the operand that feeds the shared
  // multiplier and where its product is written back.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_INIT = 3'd1;  // seed ^ (len * m)
  localparam logic [2:0] OP_K1   = 3'd2;  // k = word * m, then xor-shift
  localparam logic [2:0] OP_K2   = 3'd3;  // k = k * m
  localparam logic [2:0] OP_HK   = 3'd4;  // h = (h ^ k) * m
  localparam logic [2:0] OP_HT   = 3'd5;  // h = (h ^ tail) * m
  localparam logic [2:0] OP_FIN  = 3'd6;  // avalanche

  typedef struct packed {
    logic       load_in;
    logic       mul_start;
    logic [2:0] op;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic full_word;
    logic tail_word;
    logic is_last;
  } status_t;

  function automatic logic [63:0] byte_mask(input logic [2:0] n);
    logic [63:0] m;
    case (n)
      3'd1:    m = 64'h0000_0000_0000_00FF;
      3'd2:    m = 64'h0000_0000_0000_FFFF;
      3'd3:    m = 64'h0000_0000_00FF_FFFF;
      3'd4:    m = 64'h0000_0000_FFFF_FFFF;
      3'd5:    m = 64'h0000_00FF_FFFF_FFFF;
      3'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
      3'd7:    m = 64'h00FF_FFFF_FFFF_FFFF;
      default: m = 64'h0;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/mmh_mul.sv
// ----------------------------------------------------------------------------
// MurmurHash64A multiplier
// Low 64 bits of a 64-bit operand times the mixing constant, built from one
// 32x32 multiplier that forms the partial products in turn.
// ----------------------------------------------------------------------------
module mmh_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  import mmh_pkg::*;

  logic [63:0] a_q, acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] x, y;
  logic [63:0] prod;

  // Only three partial products reach the low 64 bits: lo*lo, and the low
  // halves of the two cross products, shifted up by 32.
  always_comb begin
    case (cnt_q)
      2'd0: begin
        x = a_q[31:0];
        y = MIX_MUL[31:0];
      end
      2'd1: begin
        x = a_q[31:0];
        y = MIX_MUL[63:32];
      end
      2'd2: begin
        x = a_q[63:32];
        y = MIX_MUL[31:0];
      end
      default: begin
        x = 32'h0;
        y = 32'h0;
      end
    endcase
    prod = 64'(x) * 64'(y);
  end

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 2'd0) begin
        acc_d = prod;
      end else begin
        acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
      end
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// File: hw/rtl/mmh_datapath.sv
// ----------------------------------------------------------------------------
// MurmurHash64A datapath
// Holds the input word, seed, running hash, mixed word and result register,
// and drives the shared multiplier under command of the controller.
// ----------------------------------------------------------------------------
module mmh_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mmh_pkg::cmd_t    cmd_i,
  output mmh_pkg::status_t status_o,
  input  logic             cfg_we_i,
  input  logic [63:0]      seed_i,
  input  logic [63:0]      data_word_i,
  input  logic [3:0]       valid_bytes_i,
  input  logic [31:0]      total_len_i,
  input  logic             last_i,
  output logic [63:0]      hash_value_o
);
  import mmh_pkg::*;

  logic [63:0] seed_q, word_q, h_q, k_q, out_q;
  logic [31:0] len_q;
  logic [3:0]  nb_q;
  logic        last_q;
  logic [2:0]  wb_op_q;
  logic [63:0] h_cur, k_cur, operand, p;
  logic        mul_done;

  mmh_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (operand),
    .done_o  (mul_done),
    .p_o     (p)
  );

  // Write-back of a finished product, forwarded so that the next operation
  // can start in the same cycle.
  always_comb begin
    h_cur = h_q;
    k_cur = k_q;
    if (mul_done) begin
      unique case (wb_op_q) inside
        OP_INIT:      h_cur = seed_q ^ p;
        OP_K1:        k_cur = p ^ (p >> MIX_SHIFT);
        OP_K2:        k_cur = p;
        OP_HK, OP_HT: h_cur = p;
        OP_FIN:       h_cur = p ^ (p >> MIX_SHIFT);
        default:      h_cur = h_q;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_INIT: operand = {32'h0, len_q};
      OP_K1:   operand = word_q;
      OP_K2:   operand = k_cur;
      OP_HK:   operand = h_cur ^ k_cur;
      OP_HT:   operand = h_cur ^ (word_q & byte_mask(nb_q[2:0]));
      OP_FIN:  operand = h_cur ^ (h_cur >> MIX_SHIFT);
      default: operand = 64'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 64'h0;
    end else if (cfg_we_i) begin
      seed_q <= seed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      word_q <= data_word_i;
      nb_q   <= (valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;
      len_q  <= total_len_i;
      last_q <= last_i;
    end
    if (cmd_i.mul_start) begin
      wb_op_q <= cmd_i.op;
    end
    if (cmd_i.out_load) begin
      out_q <= h_q;
    end
    h_q <= h_cur;
    k_q <= k_cur;
  end

  assign status_o.mul_done  = mul_done;
  assign status_o.full_word = nb_q[3];
  assign status_o.tail_word = !nb_q[3] && (nb_q[2:0] != 3'd0);
  assign status_o.is_last   = last_q;
  assign hash_value_o       = out_q;

endmodule

// File: hw/rtl/mmh_ctrl.sv
// ----------------------------------------------------------------------------
// MurmurHash64A controller
// Sequences the multiply operations for each word, tracks whether a message
// is open and owns the request handshakes on both channels.
// ----------------------------------------------------------------------------
module mmh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  mmh_pkg::status_t status_i,
  output mmh_pkg::cmd_t    cmd_o
);
  import mmh_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] op_q, op_d, nxt, word_op, fin_op;
  logic       in_msg_q, in_msg_d, out_valid_q, out_valid_d, launch;

  assign fin_op  = status_i.is_last ? OP_FIN : OP_NONE;
  assign word_op = status_i.full_word ? OP_K1 :
                   status_i.tail_word ? OP_HT : fin_op;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    nxt         = OP_NONE;
    launch      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        nxt    = in_msg_q ? word_op : OP_INIT;
        launch = 1'b1;
      end
      S_RUN: begin
        if (status_i.mul_done) begin
          launch = 1'b1;
          unique case (op_q) inside
            OP_INIT:      nxt = word_op;
            OP_K1:        nxt = OP_K2;
            OP_K2:        nxt = OP_HK;
            OP_HK, OP_HT: nxt = fin_op;
            default: begin
              launch  = 1'b0;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        // Wait for the previous result to be taken before overwriting it.
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          in_msg_d       = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (launch) begin
      if (nxt == OP_NONE) begin
        in_msg_d = 1'b1;
        state_d  = S_IDLE;
      end else begin
        cmd_o.mul_start = 1'b1;
        cmd_o.op        = nxt;
        op_d            = nxt;
        state_d         = S_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_start_spaced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |=> !cmd_o.mul_start)
    else $error("multiply started in consecutive cycles");
  a_done_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.mul_done |-> (state_q == S_RUN))
    else $error("multiply finished outside the run state");
  a_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");
  a_out_after_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (op_q == OP_FIN))
    else $error("result state reached without the avalanche");
`endif

endmodule

// File: hw/rtl/murmur64a_stream_hash.sv
// ----------------------------------------------------------------------------
// MurmurHash64A stream hash
// Hashes a byte message delivered as little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one request per word. The first
// word of a message carries total_len_i; a word with last_i set closes the
// message. valid_bytes_i is 8 for full words and 1 to 7 for a tail word.
// Output channel (out_valid_o / out_stall_i): one request per message,
// carrying hash_value_o, held in an output register.
// Configuration (cfg_valid_i / cfg_ready_o): writes the seed; always ready.
// Every 64-bit product is formed by one 32x32 multiplier from three partial
// products, and each multiply ends with a write-back. A word is accepted and
// then its multiplies are issued in turn: three for a full word, one for a
// tail and none for an empty word, plus the length term on the first word
// of a message, and the avalanche on the last word, after which the hash
// moves to the output register. One word is in flight at a time.
// A new word is accepted while a finished hash waits in the output register;
// the next result waits in the engine until that register is free.
// Reset clears the seed to zero and leaves the block waiting for a first word.
// ----------------------------------------------------------------------------
module murmur64a_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic [31:0] total_len_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);
  import mmh_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  mmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .seed_i        (seed_i),
    .data_word_i   (data_word_i),
    .valid_bytes_i (valid_bytes_i),
    .total_len_i   (total_len_i),
    .last_i        (last_i),
    .hash_value_o  (hash_value_o)
  );

endmodule
